>>> hdl/word_stream_hash64_top_assert.svh
// Assertion macros shared by the checker of word_stream_hash64_top.
// Needs a clk and an arst_n in the scope where the macros are used.
`ifndef WORD_STREAM_HASH64_TOP_ASSERT_SVH
`define WORD_STREAM_HASH64_TOP_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define WSH_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define WSH_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/wsh_pkg.sv
// Shared constants, types and helper functions of the streaming word hash.
// No dependencies; the design files of the block refer to it by scope.
package wsh_pkg;

	localparam logic [63:0] HASH_MULT = 64'h8803_55f2_1e6d_1965;
	localparam logic [63:0] MIX_MULT  = 64'h2127_599b_f432_5c37;
	localparam int MIX_SHIFT_A = 23;
	localparam int MIX_SHIFT_B = 47;

	localparam int WORD_W         = 64;
	localparam int HALF_W         = WORD_W / 2;
	localparam int BYTES_PER_WORD = WORD_W / 8;

	// Decoupling queue between front and back, and the result buffer.
	localparam int MID_DEPTH = 2;
	localparam int MID_PTR_W = (MID_DEPTH > 1) ? $clog2(MID_DEPTH) : 1;
	localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
	localparam int OUT_DEPTH = 2;
	localparam int OUT_PTR_W = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
	localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

	typedef enum logic [1:0] {
		MS_LO_LO,
		MS_LO_HI,
		MS_HI_LO
	} mul_step_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_HOLD
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_HMUL,
		B_FMUL,
		B_OUT
	} back_state_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] prod;
	} mul_rsp_t;

	// Classified word as handed from front to back.
	typedef struct packed {
		logic [WORD_W-1:0] mixed;
		logic [WORD_W-1:0] lenm;
		logic              nz;
		logic              first;
		logic              last;
	} mid_item_t;

	function automatic logic [WORD_W-1:0] xs_a(input logic [WORD_W-1:0] x);
		return x ^ (x >> MIX_SHIFT_A);
	endfunction

	function automatic logic [WORD_W-1:0] xs_b(input logic [WORD_W-1:0] x);
		return x ^ (x >> MIX_SHIFT_B);
	endfunction

endpackage

>>> hdl/word_stream_hash64_top.sv
// Streaming 64-bit word hash. Front: one word at a time through the 3-step word-mix multiply.
// Back: takes a word from the queue, then the 3-step hash-times-constant multiply (skipped for
// a word with no valid bytes), and on a last word the final mix multiply as well.
// A last word's result waits for the words still ahead of it in the back.
// Reset (arst_n low, async): seed, running hash cleared, queues emptied; uses wsh_* parts.
module word_stream_hash64_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [63:0] data_word,
	input  logic [3:0]  valid_bytes,
	input  logic        first_word,
	input  logic        last_word,
	input  logic [31:0] message_length,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] hash_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] hash_seed
);

	logic [63:0]        seed_q;
	logic               mid_wr;
	logic               mid_rd;
	logic               mid_full;
	logic               mid_empty;
	wsh_pkg::mid_item_t mid_wr_item;
	wsh_pkg::mid_item_t mid_rd_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seed_q <= '0;
		else if (cfg_valid && cfg_ready)
			seed_q <= hash_seed;
	end

	wsh_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_word      (data_word),
		.valid_bytes    (valid_bytes),
		.first_word     (first_word),
		.last_word      (last_word),
		.message_length (message_length),
		.q_wr           (mid_wr),
		.q_item         (mid_wr_item),
		.q_full         (mid_full)
	);

	wsh_queue u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_wr),
		.wr_item (mid_wr_item),
		.q_full  (mid_full),
		.rd_en   (mid_rd),
		.rd_item (mid_rd_item),
		.q_empty (mid_empty)
	);

	wsh_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed       (seed_q),
		.q_empty    (mid_empty),
		.q_item     (mid_rd_item),
		.q_rd       (mid_rd),
		.empty      (empty),
		.pop        (pop),
		.hash_value (hash_value)
	);

endmodule

>>> hdl/wsh_mul64.sv
// Iterative 64x64 multiplier keeping the low 64 bits of the product.
// One 32x32 partial product per cycle: lo*lo, then lo*hi, then hi*lo; uses wsh_pkg.
module wsh_mul64 (
	input  logic              clk,
	input  logic              arst_n,
	input  wsh_pkg::mul_req_t req,
	output wsh_pkg::mul_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	wsh_pkg::mul_step_t            step_q;
	logic [wsh_pkg::WORD_W-1:0]    a_q;
	logic [wsh_pkg::WORD_W-1:0]    b_q;
	logic [wsh_pkg::WORD_W-1:0]    acc_q;
	logic [wsh_pkg::HALF_W-1:0]    op_x;
	logic [wsh_pkg::HALF_W-1:0]    op_y;
	logic [wsh_pkg::WORD_W-1:0]    part;

	// lo*lo fills the accumulator, the two cross terms only touch its upper half
	always_comb begin
		unique case (step_q)
			wsh_pkg::MS_LO_LO: begin
				op_x = a_q[wsh_pkg::HALF_W-1:0];
				op_y = b_q[wsh_pkg::HALF_W-1:0];
			end
			wsh_pkg::MS_LO_HI: begin
				op_x = a_q[wsh_pkg::HALF_W-1:0];
				op_y = b_q[wsh_pkg::WORD_W-1:wsh_pkg::HALF_W];
			end
			default: begin
				op_x = a_q[wsh_pkg::WORD_W-1:wsh_pkg::HALF_W];
				op_y = b_q[wsh_pkg::HALF_W-1:0];
			end
		endcase
	end

	assign part = op_x * op_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= wsh_pkg::MS_LO_LO;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= wsh_pkg::MS_LO_LO;
			end else if (busy_q) begin
				unique case (step_q)
					wsh_pkg::MS_LO_LO: step_q <= wsh_pkg::MS_LO_HI;
					wsh_pkg::MS_LO_HI: step_q <= wsh_pkg::MS_HI_LO;
					default: begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			if (step_q == wsh_pkg::MS_LO_LO)
				acc_q <= part;
			else
				acc_q[wsh_pkg::WORD_W-1:wsh_pkg::HALF_W] <=
					acc_q[wsh_pkg::WORD_W-1:wsh_pkg::HALF_W] + part[wsh_pkg::HALF_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

>>> hdl/wsh_queue.sv
// Two-entry queue of classified words between the front and the back.
// Item type and depth come from wsh_pkg.
module wsh_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  wsh_pkg::mid_item_t wr_item,
	output logic               q_full,
	input  logic               rd_en,
	output wsh_pkg::mid_item_t rd_item,
	output logic               q_empty
);

	wsh_pkg::mid_item_t                mem_q [wsh_pkg::MID_DEPTH];
	logic [wsh_pkg::MID_PTR_W-1:0]     wr_ptr_q;
	logic [wsh_pkg::MID_PTR_W-1:0]     rd_ptr_q;
	logic [wsh_pkg::MID_CNT_W-1:0]     cnt_q;
	logic                              do_wr;
	logic                              do_rd;

	assign q_full  = (cnt_q == wsh_pkg::MID_CNT_W'(wsh_pkg::MID_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == wsh_pkg::MID_PTR_W'(wsh_pkg::MID_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == wsh_pkg::MID_PTR_W'(wsh_pkg::MID_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

>>> hdl/wsh_front.sv
// Front end: takes message words, masks the tail bytes and runs the word mix
// and the length product on two wsh_mul64 units; uses wsh_pkg.
module wsh_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [63:0]        data_word,
	input  logic [3:0]         valid_bytes,
	input  logic               first_word,
	input  logic               last_word,
	input  logic [31:0]        message_length,
	output logic               q_wr,
	output wsh_pkg::mid_item_t q_item,
	input  logic               q_full
);

	wsh_pkg::front_state_t      state_q;
	wsh_pkg::front_state_t      state_d;
	logic                       ready;
	logic                       accept;
	logic [3:0]                 nb;
	logic [wsh_pkg::WORD_W-1:0] masked;
	logic                       nz_q;
	logic                       first_q;
	logic                       last_q;
	wsh_pkg::mul_req_t          wmul_req;
	wsh_pkg::mul_rsp_t          wmul_rsp;
	wsh_pkg::mul_req_t          lmul_req;
	wsh_pkg::mul_rsp_t          lmul_rsp;

	// byte counts above eight saturate
	assign nb = (valid_bytes > 4'(wsh_pkg::BYTES_PER_WORD)) ?
		4'(wsh_pkg::BYTES_PER_WORD) : valid_bytes;

	always_comb begin
		for (int i = 0; i < wsh_pkg::BYTES_PER_WORD; i++)
			masked[i*8 +: 8] = (4'(i) < nb) ? data_word[i*8 +: 8] : 8'h00;
	end

	always_comb begin
		state_d = state_q;
		ready   = 1'b0;
		q_wr    = 1'b0;
		unique case (state_q)
			wsh_pkg::F_IDLE: begin
				ready = 1'b1;
			end
			wsh_pkg::F_MUL: begin
				if (wmul_rsp.done) begin
					if (!q_full) begin
						q_wr    = 1'b1;
						ready   = 1'b1;
						state_d = wsh_pkg::F_IDLE;
					end else begin
						state_d = wsh_pkg::F_HOLD;
					end
				end
			end
			wsh_pkg::F_HOLD: begin
				if (!q_full) begin
					q_wr    = 1'b1;
					ready   = 1'b1;
					state_d = wsh_pkg::F_IDLE;
				end
			end
			default: state_d = wsh_pkg::F_IDLE;
		endcase
		if (push && ready)
			state_d = wsh_pkg::F_MUL;
	end

	assign full   = !ready;
	assign accept = push && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= wsh_pkg::F_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			nz_q    <= (nb != 4'd0);
			first_q <= first_word;
			last_q  <= last_word;
		end
	end

	assign wmul_req.start = accept;
	assign wmul_req.a     = wsh_pkg::xs_a(masked);
	assign wmul_req.b     = wsh_pkg::MIX_MULT;
	assign lmul_req.start = accept;
	assign lmul_req.a     = {32'h0, message_length};
	assign lmul_req.b     = wsh_pkg::HASH_MULT;

	wsh_mul64 u_word_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (wmul_req),
		.rsp    (wmul_rsp)
	);

	wsh_mul64 u_len_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lmul_req),
		.rsp    (lmul_rsp)
	);

	// products hold in the multipliers until the next accepted word
	assign q_item.mixed = wsh_pkg::xs_b(wmul_rsp.prod);
	assign q_item.lenm  = lmul_rsp.prod;
	assign q_item.nz    = nz_q;
	assign q_item.first = first_q;
	assign q_item.last  = last_q;

endmodule

>>> hdl/wsh_back.sv
// Back end: running hash recurrence, final mix and the result buffer.
// One shared wsh_mul64 serves both multiplies; uses wsh_pkg.
module wsh_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [63:0]        seed,
	input  logic               q_empty,
	input  wsh_pkg::mid_item_t q_item,
	output logic               q_rd,
	output logic               empty,
	input  logic               pop,
	output logic [63:0]        hash_value
);

	wsh_pkg::back_state_t          state_q;
	wsh_pkg::back_state_t          state_d;
	logic [wsh_pkg::WORD_W-1:0]    run_q;
	logic [wsh_pkg::WORD_W-1:0]    run_d;
	logic                          run_en;
	logic                          last_q;
	logic [wsh_pkg::WORD_W-1:0]    h0;
	wsh_pkg::mul_req_t             mul_req;
	wsh_pkg::mul_rsp_t             mul_rsp;
	logic [wsh_pkg::WORD_W-1:0]    ob_mem_q [wsh_pkg::OUT_DEPTH];
	logic [wsh_pkg::OUT_PTR_W-1:0] ob_wr_q;
	logic [wsh_pkg::OUT_PTR_W-1:0] ob_rd_q;
	logic [wsh_pkg::OUT_CNT_W-1:0] ob_cnt_q;
	logic                          ob_full;
	logic                          ob_wr;
	logic                          ob_rd;

	assign h0 = q_item.first ? (seed ^ q_item.lenm) : run_q;

	always_comb begin
		state_d       = state_q;
		q_rd          = 1'b0;
		run_en        = 1'b0;
		run_d         = mul_rsp.prod;
		ob_wr         = 1'b0;
		mul_req.start = 1'b0;
		mul_req.a     = q_item.mixed ^ h0;
		mul_req.b     = wsh_pkg::HASH_MULT;
		unique case (state_q)
			wsh_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_rd = 1'b1;
					if (q_item.nz) begin
						mul_req.start = 1'b1;
						state_d       = wsh_pkg::B_HMUL;
					end else begin
						// no bytes: hash passes unchanged
						run_en = 1'b1;
						run_d  = h0;
						if (q_item.last) begin
							mul_req.start = 1'b1;
							mul_req.a     = wsh_pkg::xs_a(h0);
							mul_req.b     = wsh_pkg::MIX_MULT;
							state_d       = wsh_pkg::B_FMUL;
						end
					end
				end
			end
			wsh_pkg::B_HMUL: begin
				if (mul_rsp.done) begin
					run_en = 1'b1;
					if (last_q) begin
						mul_req.start = 1'b1;
						mul_req.a     = wsh_pkg::xs_a(mul_rsp.prod);
						mul_req.b     = wsh_pkg::MIX_MULT;
						state_d       = wsh_pkg::B_FMUL;
					end else begin
						state_d = wsh_pkg::B_IDLE;
					end
				end
			end
			wsh_pkg::B_FMUL: begin
				if (mul_rsp.done) begin
					if (!ob_full) begin
						ob_wr   = 1'b1;
						state_d = wsh_pkg::B_IDLE;
					end else begin
						state_d = wsh_pkg::B_OUT;
					end
				end
			end
			wsh_pkg::B_OUT: begin
				if (!ob_full) begin
					ob_wr   = 1'b1;
					state_d = wsh_pkg::B_IDLE;
				end
			end
			default: state_d = wsh_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsh_pkg::B_IDLE;
			run_q   <= '0;
		end else begin
			state_q <= state_d;
			if (run_en)
				run_q <= run_d;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd)
			last_q <= q_item.last;
	end

	wsh_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// result buffer
	assign ob_full    = (ob_cnt_q == wsh_pkg::OUT_CNT_W'(wsh_pkg::OUT_DEPTH));
	assign empty      = (ob_cnt_q == '0);
	assign ob_rd      = pop && !empty;
	assign hash_value = ob_mem_q[ob_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_wr_q  <= '0;
			ob_rd_q  <= '0;
			ob_cnt_q <= '0;
		end else begin
			if (ob_wr)
				ob_wr_q <= (ob_wr_q == wsh_pkg::OUT_PTR_W'(wsh_pkg::OUT_DEPTH - 1)) ?
					'0 : ob_wr_q + 1'b1;
			if (ob_rd)
				ob_rd_q <= (ob_rd_q == wsh_pkg::OUT_PTR_W'(wsh_pkg::OUT_DEPTH - 1)) ?
					'0 : ob_rd_q + 1'b1;
			if (ob_wr && !ob_rd)
				ob_cnt_q <= ob_cnt_q + 1'b1;
			else if (ob_rd && !ob_wr)
				ob_cnt_q <= ob_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ob_wr)
			ob_mem_q[ob_wr_q] <= wsh_pkg::xs_b(mul_rsp.prod);
	end

endmodule

>>> hdl/wsh_checker.sv
// Port-level checks for word_stream_hash64_top, attached by bind.
// Uses the macros of word_stream_hash64_top_assert.svh.
`include "word_stream_hash64_top_assert.svh"

module wsh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [63:0] hash_value,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// in reset: nothing waiting, front open
	`WSH_ASSERT_RST(a_reset_idle, !arst_n |-> (empty && !full), "not idle in reset")

	// an accepted request keeps the front busy for the three multiply steps
	`WSH_ASSERT_CLK(a_front_busy, (push && !full) |=> full ##1 full ##1 full, "front reopened early")

	`WSH_ASSERT_CLK(a_result_hold, (!empty && !pop) |=> (!empty && $stable(hash_value)), "result dropped")

	`WSH_ASSERT_CLK(a_cfg_ready, cfg_valid |-> cfg_ready, "config write refused")

endmodule

bind word_stream_hash64_top wsh_checker u_wsh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.push       (push),
	.full       (full),
	.empty      (empty),
	.pop        (pop),
	.hash_value (hash_value),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready)
);
